@@ rtl/core/fire_field_blur_engine_core_assert.svh @@
// Assertion macros for the fire field blur engine checker.
`ifndef FIRE_FIELD_BLUR_ENGINE_CORE_ASSERT_SVH
`define FIRE_FIELD_BLUR_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FFBE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FFBE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ffbe_pkg.sv @@
// Shared constants, codes and types of the fire field blur engine.
package ffbe_pkg;

    localparam int LINE_W     = 256;
    localparam int FIELD_SIZE = 65536;
    localparam int ADDR_W     = $clog2(FIELD_SIZE);
    localparam int PIX_W      = 8;
    localparam int WIN_LEN    = 2 * LINE_W + 1;
    localparam int SUM_W      = PIX_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int OP_W       = 2;

    localparam logic [ADDR_W-1:0] ADDR_LAST       = ADDR_W'(FIELD_SIZE - 1);
    localparam logic [ADDR_W-1:0] LINE_OFS        = ADDR_W'(LINE_W);
    localparam logic [ADDR_W-1:0] TWO_LINE_OFS    = ADDR_W'(2 * LINE_W);
    localparam logic [ADDR_W-1:0] BLUR_EMIT_FIRST = ADDR_W'(2 * LINE_W + 1);
    localparam logic [ADDR_W-1:0] BLUR_RD_LAST    = ADDR_W'(FIELD_SIZE - LINE_W);
    localparam logic [ADDR_W-1:0] DARK_RD_FIRST   = ADDR_W'(LINE_W);

    // Operation codes carried on the input kind field.
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLUR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DARK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONVECT = 2'd2;

    typedef struct packed {
        logic blur;
        logic dark;
        logic convect;
    } ffbe_cfg_t;

    typedef struct packed {
        logic              shift;
        logic              emit;
        logic              blur_mode;
        logic              dark;
        logic [ADDR_W-1:0] tag;
    } ffbe_unit_ctl_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
        logic              busy;
    } ffbe_unit_out_t;

    typedef struct packed {
        logic [PIX_W-1:0] read_value;
        logic             step_done;
    } ffbe_resp_t;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_RDWAIT = 8'b0000_0100,
        ST_BLUR   = 8'b0000_1000,
        ST_DARK   = 8'b0001_0000,
        ST_DRAIN  = 8'b0010_0000,
        ST_COPY   = 8'b0100_0000,
        ST_RESP   = 8'b1000_0000
    } ffbe_state_t;

endpackage

@@ rtl/core/fire_field_blur_engine_core.sv @@
// A write or unused op goes straight to the response state; a read first waits for the RAM read.
// A blur step reads 65,281 pixels, drains the pixel unit, copies 65,536 entries back and responds.
// A darken step reads 65,280 pixels, drains the pixel unit and then responds.
// The rate is set by the single read port of the field RAM feeding the shared pixel unit.
// Reset (aresetn low, synchronous) clears the registers, then a sweep over every address zeroes
// both stores while s_tready stays low; configuration writes are taken throughout.
module fire_field_blur_engine_core
    import ffbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [15:0] pixel_address, [23:16] pixel_value
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] op
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,   // [7:0] read_value
    output logic                 m_tuser,   // [0] step_done
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    ffbe_cfg_t         cfg_reg, cfg_next;
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  m_data_reg;
    logic              m_user_reg;

    logic              resp_valid;
    logic              resp_free;
    ffbe_resp_t        resp;

    logic              f_we, w_we;
    logic [ADDR_W-1:0] f_waddr, f_raddr, w_waddr, w_raddr;
    logic [PIX_W-1:0]  f_wdata, f_rdata, w_wdata, w_rdata;
    ffbe_unit_ctl_t    ctl;
    ffbe_unit_out_t    uo;

    // Configuration is always accepted; an index past the register list is dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BLUR:    cfg_next.blur    = cfg_data;
                REG_DARK:    cfg_next.dark    = cfg_data;
                REG_CONVECT: cfg_next.convect = cfg_data;
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    // The output register frees the sequencer as soon as a result is handed over,
    // so the next input beat can be accepted while this one waits downstream.
    assign resp_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (resp_valid && resp_free) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_valid && resp_free) begin
            m_data_reg <= resp.read_value;
            m_user_reg <= resp.step_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    ffbe_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_addr    (s_tdata[ADDR_W-1:0]),
        .in_value   (s_tdata[ADDR_W +: PIX_W]),
        .resp_valid (resp_valid),
        .resp_free  (resp_free),
        .resp       (resp),
        .f_we       (f_we),
        .f_waddr    (f_waddr),
        .f_wdata    (f_wdata),
        .f_raddr    (f_raddr),
        .f_rdata    (f_rdata),
        .w_we       (w_we),
        .w_waddr    (w_waddr),
        .w_wdata    (w_wdata),
        .w_raddr    (w_raddr),
        .w_rdata    (w_rdata),
        .ctl        (ctl),
        .uo         (uo)
    );

    // The field store holds the visible intensities.
    ffbe_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W)
    ) u_field_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // The work store collects blur results before they are copied back.
    ffbe_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W)
    ) u_work_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // Every field read during a step streams through this one unit.
    ffbe_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .din     (f_rdata),
        .uo      (uo)
    );

endmodule

@@ rtl/core/ffbe_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module ffbe_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ffbe_filter.sv @@
// Shared pixel unit: a raster window of two lines plus one pixel, and the blur and darken arithmetic.
module ffbe_filter
    import ffbe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ffbe_unit_ctl_t   ctl,
    input  logic [PIX_W-1:0] din,
    output ffbe_unit_out_t   uo
);

    // Tap k holds the pixel read k beats before the newest one.
    logic [PIX_W-1:0]  win_reg [WIN_LEN];
    logic              emit2_reg;
    logic              blur2_reg;
    logic              dark2_reg;
    logic [ADDR_W-1:0] tag2_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [PIX_W-1:0]  out_data_reg;

    logic [SUM_W-1:0]  sum;
    logic [PIX_W:0]    mix;
    logic [PIX_W-1:0]  base;
    logic [PIX_W-1:0]  result;

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            win_reg[0] <= din;
            for (int i = 1; i < WIN_LEN; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            emit2_reg     <= ctl.shift & ctl.emit;
            out_valid_reg <= emit2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        tag2_reg     <= ctl.tag;
        blur2_reg    <= ctl.blur_mode;
        dark2_reg    <= ctl.dark;
        out_addr_reg <= tag2_reg;
        out_data_reg <= result;
    end

    // The window centre sits one line behind the newest tap.
    always_comb begin
        sum = SUM_W'(win_reg[LINE_W-1]) + SUM_W'(win_reg[LINE_W+1])
            + SUM_W'(win_reg[2*LINE_W]) + SUM_W'(win_reg[0]);
        mix = (PIX_W+1)'(sum[SUM_W-1:2]) + (PIX_W+1)'(win_reg[LINE_W]);
        base = blur2_reg ? mix[PIX_W:1] : win_reg[0];
        if (dark2_reg && (base != '0)) begin
            result = base - PIX_W'(1);
        end else begin
            result = base;
        end
    end

    assign uo.valid = out_valid_reg;
    assign uo.addr  = out_addr_reg;
    assign uo.data  = out_data_reg;
    assign uo.busy  = emit2_reg | out_valid_reg;

endmodule

@@ rtl/core/ffbe_seq.sv @@
// Sequencer: clearing sweep, pixel access, blur, darken and copy passes.
module ffbe_seq
    import ffbe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ffbe_cfg_t         cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [ADDR_W-1:0] in_addr,
    input  logic [PIX_W-1:0]  in_value,
    output logic              resp_valid,
    input  logic              resp_free,
    output ffbe_resp_t        resp,
    output logic              f_we,
    output logic [ADDR_W-1:0] f_waddr,
    output logic [PIX_W-1:0]  f_wdata,
    output logic [ADDR_W-1:0] f_raddr,
    input  logic [PIX_W-1:0]  f_rdata,
    output logic              w_we,
    output logic [ADDR_W-1:0] w_waddr,
    output logic [PIX_W-1:0]  w_wdata,
    output logic [ADDR_W-1:0] w_raddr,
    input  logic [PIX_W-1:0]  w_rdata,
    output ffbe_unit_ctl_t    ctl,
    input  ffbe_unit_out_t    uo
);

    ffbe_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              emit1_reg, emit1_next;
    logic [ADDR_W-1:0] tag1_reg, tag1_next;
    logic              cp_pend_reg, cp_pend_next;
    logic [ADDR_W-1:0] cp_addr_reg, cp_addr_next;
    ffbe_resp_t        resp_reg, resp_next;
    logic              accept;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid & in_ready;
    assign resp_valid = (state_reg == ST_RESP);
    assign resp       = resp_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_pend_next = 1'b0;
        emit1_next   = 1'b0;
        tag1_next    = tag1_reg;
        cp_pend_next = 1'b0;
        cp_addr_next = cp_addr_reg;
        resp_next    = resp_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    resp_next = '0;
                    unique case (in_op)
                        OP_WRITE: state_next = ST_RESP;
                        OP_READ:  state_next = ST_RDWAIT;
                        OP_STEP: begin
                            resp_next.step_done = 1'b1;
                            if (cfg.blur) begin
                                cnt_next   = '0;
                                state_next = ST_BLUR;
                            end else begin
                                cnt_next   = DARK_RD_FIRST;
                                state_next = ST_DARK;
                            end
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_RDWAIT: begin
                resp_next.read_value = f_rdata;
                state_next           = ST_RESP;
            end
            ST_BLUR: begin
                rd_pend_next = 1'b1;
                emit1_next   = (cnt_reg >= BLUR_EMIT_FIRST);
                tag1_next    = cnt_reg - (cfg.convect ? TWO_LINE_OFS : LINE_OFS);
                cnt_next     = cnt_reg + ADDR_W'(1);
                if (cnt_reg == BLUR_RD_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DARK: begin
                rd_pend_next = 1'b1;
                emit1_next   = 1'b1;
                tag1_next    = cnt_reg - (cfg.convect ? LINE_OFS : '0);
                cnt_next     = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_pend_reg && !uo.busy) begin
                    cnt_next   = '0;
                    state_next = cfg.blur ? ST_COPY : ST_RESP;
                end
            end
            ST_COPY: begin
                cp_pend_next = 1'b1;
                cp_addr_next = cnt_reg;
                cnt_next     = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_LAST) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (resp_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            emit1_reg   <= 1'b0;
            cp_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            emit1_reg   <= emit1_next;
            cp_pend_reg <= cp_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag1_reg    <= tag1_next;
        cp_addr_reg <= cp_addr_next;
        resp_reg    <= resp_next;
    end

    // Field write port: only one source is ever active at a time.
    always_comb begin
        f_we    = 1'b0;
        f_waddr = cnt_reg;
        f_wdata = '0;
        priority if (state_reg == ST_CLEAR) begin
            f_we = 1'b1;
        end else if (cp_pend_reg) begin
            f_we    = 1'b1;
            f_waddr = cp_addr_reg;
            f_wdata = w_rdata;
        end else if (uo.valid && !cfg.blur) begin
            f_we    = 1'b1;
            f_waddr = uo.addr;
            f_wdata = uo.data;
        end else if (accept && (in_op == OP_WRITE)) begin
            f_we    = 1'b1;
            f_waddr = in_addr;
            f_wdata = in_value;
        end else begin
            f_we = 1'b0;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = cnt_reg;
        w_wdata = '0;
        priority if (state_reg == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (uo.valid && cfg.blur) begin
            w_we    = 1'b1;
            w_waddr = uo.addr;
            w_wdata = uo.data;
        end else begin
            w_we = 1'b0;
        end
    end

    assign f_raddr = (state_reg == ST_IDLE) ? in_addr : cnt_reg;
    assign w_raddr = cnt_reg;

    assign ctl.shift     = rd_pend_reg;
    assign ctl.emit      = emit1_reg;
    assign ctl.blur_mode = cfg.blur;
    assign ctl.dark      = cfg.dark;
    assign ctl.tag       = tag1_reg;

endmodule

@@ rtl/core/ffbe_checker.sv @@
// Port-level checker for the fire field blur engine and its bind statement.
`include "fire_field_blur_engine_core_assert.svh"

module ffbe_checker
    import ffbe_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [OP_W-1:0]      s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [PIX_W-1:0]     m_tdata,
    input logic                 m_tuser
);

    `FFBE_ASSERT_NXT(a_out_valid_hold, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `FFBE_ASSERT_NXT(a_out_data_hold, aclk, aresetn,
        m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser),
        "result beat changed while stalled")
    `FFBE_ASSERT_IMP(a_step_no_value, aclk, aresetn,
        m_tvalid && m_tuser, m_tdata == '0, "frame step result carries a read value")
    `FFBE_ASSERT_NXT(a_step_busy, aclk, aresetn,
        s_tvalid && s_tready && (s_tuser == OP_STEP), !s_tready,
        "input taken right after a frame step began")

endmodule

bind fire_field_blur_engine_core ffbe_checker u_ffbe_checker (.*);

@@ tb/fire_field_blur_engine_core_tb.sv @@
// Self-checking testbench for the fire field blur engine core: pixel traffic and frame steps.
`timescale 1ns / 1ps

module fire_field_blur_engine_core_tb;
    import ffbe_pkg::*;

    // The op field is two bits wide, so one code is left over. The block must ignore it.
    localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
    // Register index past the end of the register list. Writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_NONE  = 2'd3;

    // Most random pixel traffic lands in a band of rows near the middle of the field.
    // This keeps reads, writes and blur results close enough to interact.
    localparam int HOT_ROW_LO = 126;
    localparam int HOT_ROW_HI = 133;
    localparam int RECENT_MAX = 32;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [ADDR_W+PIX_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic                  cfg_data  = 1'b0;

    always #5 aclk = ~aclk;

    fire_field_blur_engine_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [15:0] pixel_address, [23:16] pixel_value
        .s_tuser   (s_tuser),   // [1:0] op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] read_value
        .m_tuser   (m_tuser),   // [0] step_done
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's state. Both stores start at zero, as the block's
    // clearing sweep leaves them, and the registers start at their reset value of zero.
    bit [PIX_W-1:0]    field_img [FIELD_SIZE];
    bit [PIX_W-1:0]    work_img  [FIELD_SIZE];
    bit                cfg_blur;
    bit                cfg_dark;
    bit                cfg_convect;

    // Result beats still owed by the block, oldest first.
    ffbe_resp_t        resp_due [$];
    // Addresses written lately, so that random reads often hit live pixels.
    logic [ADDR_W-1:0] recent_addrs [$];

    int  err_count   = 0;
    // While set, neither side inserts random idle cycles.
    bit  steady      = 1'b0;
    // Number of cycles the result side must still hold m_tready low.
    int  hold_cycles = 0;

    // Convection blur: each interior pixel becomes the average of its centre and the
    // mean of its four neighbours, optionally darkened by one and moved up one line.
    // Results go to the work store, which then replaces the whole field. Work store
    // entries that the pass does not reach keep whatever they held before.
    function automatic void blur_frame();
        int sum;
        int v;
        int dst;
        for (int c = LINE_W + 1; c <= FIELD_SIZE - 2 * LINE_W; c++) begin
            sum = int'(field_img[c - 1]) + int'(field_img[c + 1])
                + int'(field_img[c - LINE_W]) + int'(field_img[c + LINE_W]);
            v = ((sum >> 2) + int'(field_img[c])) >> 1;
            if (cfg_dark && v != 0) begin
                v--;
            end
            dst = cfg_convect ? c - LINE_W : c;
            work_img[dst] = PIX_W'(v);
        end
        field_img = work_img;
    endfunction

    // Darkening pass, done in place in rising address order. Row zero is never read;
    // with convection it is only a destination and the last row is only a source. A zero pixel
    // stays zero rather than wrapping to full intensity.
    function automatic void darken_frame();
        int v;
        int dst;
        for (int c = LINE_W; c < FIELD_SIZE; c++) begin
            v = int'(field_img[c]);
            if (cfg_dark && v != 0) begin
                v--;
            end
            dst = cfg_convect ? c - LINE_W : c;
            field_img[dst] = PIX_W'(v);
        end
    endfunction

    // Applies one accepted input beat to the shadow state and returns the result
    // beat that the block owes for it.
    function automatic ffbe_resp_t apply_pixel_op(input logic [OP_W-1:0]   op,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [PIX_W-1:0]  val);
        ffbe_resp_t r;
        r = '0;
        case (op)
            OP_WRITE: begin
                field_img[addr] = val;
            end
            OP_READ: begin
                r.read_value = field_img[addr];
            end
            OP_STEP: begin
                if (cfg_blur) begin
                    blur_frame();
                end else begin
                    darken_frame();
                end
                r.step_done = 1'b1;
            end
            default: begin
                // The unused code leaves the state alone and returns an all-zero beat.
            end
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] hot_addr();
        return ADDR_W'($urandom_range(HOT_ROW_HI, HOT_ROW_LO) * LINE_W
                       + $urandom_range(LINE_W - 1, 0));
    endfunction

    // Offers one input beat and returns at the rising edge where it is accepted.
    // The caller must follow up at the next falling edge, either with another beat
    // or by parking the sender, so that s_tvalid never lingers on a taken beat.
    task automatic send_item(input logic [OP_W-1:0]   op,
                             input logic [ADDR_W-1:0] addr,
                             input logic [PIX_W-1:0]  val);
        int gap;
        gap = (!steady && $urandom_range(99) < 28) ? $urandom_range(4, 1) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {val, addr};
        do @(posedge aclk); while (!s_tready);
        resp_due.push_back(apply_pixel_op(op, addr, val));
    endtask

    task automatic park_sender();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Every beat has a result, so an empty queue means the block is idle.
    task automatic wait_results_drained();
        park_sender();
        while (resp_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BLUR:    cfg_blur    = data;
            REG_DARK:    cfg_dark    = data;
            REG_CONVECT: cfg_convect = data;
            default: begin
                // Writes past the register list are dropped by the block.
            end
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_regs(input bit blur, input bit dark, input bit convect);
        wait_results_drained();
        write_reg(REG_BLUR, blur);
        write_reg(REG_DARK, dark);
        write_reg(REG_CONVECT, convect);
    endtask

    // One random pixel beat. Writes and reads dominate, most of them in the hot band
    // or on recently written addresses; a few go anywhere in the field, and a few
    // carry the unused op code.
    task automatic random_pixel_beat();
        int                pick;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        if (pick < 40 || (pick >= 92 && pick < 95)) begin
            addr = (pick < 40) ? hot_addr() : ADDR_W'($urandom);
            send_item(OP_WRITE, addr, PIX_W'($urandom));
            recent_addrs.push_back(addr);
            if (recent_addrs.size() > RECENT_MAX) begin
                void'(recent_addrs.pop_front());
            end
        end else if (pick < 75 && recent_addrs.size() != 0) begin
            addr = recent_addrs[$urandom_range(recent_addrs.size() - 1, 0)];
            send_item(OP_READ, addr, PIX_W'($urandom));
        end else if (pick < 95) begin
            addr = (pick < 92) ? hot_addr() : ADDR_W'($urandom);
            send_item(OP_READ, addr, PIX_W'($urandom));
        end else begin
            send_item(OP_UNUSED, ADDR_W'($urandom), PIX_W'($urandom));
        end
    endtask

    // Field corners and pixel value extremes, plus the unused op code, which must
    // neither disturb pixel zero nor return anything but zeros.
    task automatic test_pixel_extremes();
        send_item(OP_WRITE, 16'h0000, 8'hFF);
        send_item(OP_WRITE, 16'hFFFF, 8'hFF);
        send_item(OP_WRITE, 16'h0101, 8'h01);
        send_item(OP_WRITE, 16'h5A5A, 8'h00);
        send_item(OP_READ,  16'h0000, 8'hA5);
        send_item(OP_READ,  16'hFFFF, 8'h5A);
        send_item(OP_READ,  16'h0101, 8'h00);
        send_item(OP_UNUSED, 16'h0000, 8'h00);
        send_item(OP_READ,  16'h0000, 8'hFF);
        // Never written: still zero from the clearing sweep.
        send_item(OP_READ,  16'h1234, 8'h00);
    endtask

    // Darkening pass, first as a plain copy, then darkened and moved up one line.
    // The pixel holding one goes to zero, the zero pixel does not wrap, and the
    // last row keeps its value because nothing is copied into it.
    task automatic test_darken_steps();
        program_regs(1'b0, 1'b0, 1'b0);
        write_reg(REG_NONE, 1'b1);
        send_item(OP_STEP, ADDR_W'($urandom), PIX_W'($urandom));
        send_item(OP_READ, 16'h0101, 8'h00);
        program_regs(1'b0, 1'b1, 1'b1);
        send_item(OP_STEP, ADDR_W'($urandom), PIX_W'($urandom));
        send_item(OP_READ, 16'h0001, 8'h00);
        send_item(OP_READ, 16'h595A, 8'h00);
        send_item(OP_READ, 16'hFFFF, 8'h00);
        send_item(OP_READ, 16'hFEFF, 8'h00);
    endtask

    // Blur pass around a single bright pixel, plain and then darkened with convection.
    task automatic test_blur_steps();
        send_item(OP_WRITE, 16'h8080, 8'hFF);
        program_regs(1'b1, 1'b0, 1'b0);
        send_item(OP_STEP, ADDR_W'($urandom), PIX_W'($urandom));
        send_item(OP_READ, 16'h8080, 8'h00);
        send_item(OP_READ, 16'h8180, 8'h00);
        program_regs(1'b1, 1'b1, 1'b1);
        send_item(OP_STEP, ADDR_W'($urandom), PIX_W'($urandom));
        send_item(OP_READ, 16'h7F80, 8'h00);
        send_item(OP_READ, 16'h8080, 8'h00);
    endtask

    // The result side stops for a long stretch while the sender keeps offering beats,
    // so the block's buffering fills and it must stall its input. Afterwards the
    // sender waits until every owed result has come before going on.
    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (16) random_pixel_beat();
        wait_results_drained();
        repeat (4) random_pixel_beat();
    endtask

    // Random pixel traffic with two frame steps along the way, the first a blur, otherwise at random settings.
    // A stretch in the middle runs with no idle cycles on either side.
    task automatic test_random_traffic();
        for (int n = 0; n < 60; n++) begin
            steady = (n >= 24 && n < 48);
            if (n == 18 || n == 42) begin
                program_regs((n == 18) ? 1'b1 : 1'($urandom), 1'($urandom), 1'($urandom));
                send_item(OP_STEP, ADDR_W'($urandom), PIX_W'($urandom));
            end else begin
                random_pixel_beat();
            end
        end
        steady = 1'b0;
    endtask

    // Result side ready. It idles at random, but not while steady is set, and a pending hold-off
    // overrides both: it is counted down here, one cycle per falling edge.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready    = 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready = steady || ($urandom_range(99) >= 28);
            end
        end
    end

    // Compares each result beat with the oldest owed result.
    always @(posedge aclk) begin
        ffbe_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (resp_due.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result beat, read_value %0d step_done %0d",
                         $time, m_tdata, m_tuser);
            end else begin
                want = resp_due.pop_front();
                if (m_tdata !== want.read_value) begin
                    err_count++;
                    $display("%0t: read_value mismatch, expected %0d, actual %0d",
                             $time, want.read_value, m_tdata);
                end
                if (m_tuser !== want.step_done) begin
                    err_count++;
                    $display("%0t: step_done mismatch, expected %0d, actual %0d",
                             $time, want.step_done, m_tuser);
                end
            end
        end
    end

    // Watchdog. Its limit lies beyond the slowest correct run, which includes
    // the clearing sweep after reset and four blur steps.
    initial begin
        #40_000_000;
        $display("fire_field_blur_engine_core_tb: FAIL");
        $finish;
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_pixel_extremes();
        test_darken_steps();
        test_blur_steps();
        test_backpressure();
        test_random_traffic();

        wait_results_drained();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("fire_field_blur_engine_core_tb: PASS");
        end else begin
            $display("fire_field_blur_engine_core_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ffbe_pkg.sv
rtl/core/ffbe_ram.sv
rtl/core/ffbe_filter.sv
rtl/core/ffbe_seq.sv
rtl/core/fire_field_blur_engine_core.sv
rtl/core/ffbe_checker.sv
tb/fire_field_blur_engine_core_tb.sv
